>>> src/pwfs_pkg.sv
package pwfs_pkg;

  localparam int unsigned MaxVarintBytes = 10;
  localparam int unsigned DefMaxGroupDepth = 255;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_FIX32  = 3'd5;
  localparam logic [2:0] WT_RES6   = 3'd6;
  localparam logic [2:0] WT_RES7   = 3'd7;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TAG       = 4'd1;
  localparam logic [3:0] ERR_FIELD     = 4'd2;
  localparam logic [3:0] ERR_WIRE      = 4'd3;
  localparam logic [3:0] ERR_EGROUP    = 4'd4;
  localparam logic [3:0] ERR_VARINT    = 4'd5;
  localparam logic [3:0] ERR_FIX64     = 4'd6;
  localparam logic [3:0] ERR_FIX32     = 4'd7;
  localparam logic [3:0] ERR_LENGTH    = 4'd8;
  localparam logic [3:0] ERR_OVERRUN   = 4'd9;
  localparam logic [3:0] ERR_OPEN      = 4'd10;
  localparam logic [3:0] ERR_DEPTH     = 4'd11;

  localparam logic [7:0] CFG_MSG_LEN = 8'd0;
  localparam logic [7:0] CFG_MAX_FN  = 8'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [3:0]  status;
    logic        last;
  } result_t;

endpackage

>>> src/protobuf_wire_field_scanner.sv
// Channel  Dir  Handshake            Payload
// in_      in   in_valid/in_ready    in_data_byte
// out_     out  out_valid/out_ready  kind, field_number, wire_type, value,
//                                    payload_byte, last_payload, status, last
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte a cycle while in_ready is high: each byte taken is parsed in one
// pass and its zero, one or two results go into a four-entry result queue.
// in_ready holds while the queue has room for two results; a stalled output
// fills the queue and then backs up the input.
// Reset (rst_n low, synchronous) puts the parser at the start of a message
// and empties the queue; the registers return to their reset values.
module protobuf_wire_field_scanner #(
  parameter int unsigned MAX_GROUP_DEPTH = pwfs_pkg::DefMaxGroupDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [28:0] out_field_number,
  output logic [2:0]  out_wire_type,
  output logic [63:0] out_value,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_payload,
  output logic [3:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pwfs_pkg::*;

  localparam int unsigned DW = $clog2(MAX_GROUP_DEPTH + 1);
  localparam logic [DW-1:0] DepthMax = DW'(MAX_GROUP_DEPTH);

  // registers
  logic [31:0] msg_len_r;
  logic [28:0] max_fn_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [28:0] fn_r, fn_nxt;
  logic [2:0]  wt_r, wt_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] used_r, used_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [3:0]  fail_r, fail_nxt;

  // result queue
  result_t     q_mem [4];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  qcnt_r;

  logic        acc_in, pop;
  result_t     res0, res1;
  logic [1:0]  nres;

  assign cfg_ready = 1'b1;
  assign in_ready  = (qcnt_r < 3'd3);
  assign acc_in    = in_valid && in_ready;
  assign out_valid = (qcnt_r != 3'd0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= 32'd1;
      max_fn_r  <= 29'h1FFF_FFFF;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MSG_LEN) msg_len_r <= cfg_data;
      else if (cfg_index == CFG_MAX_FN) max_fn_r <= cfg_data[28:0];
    end
  end

  // per-byte parse step: tag, varint, fixed, length and payload
  logic [6:0]  vshamt;
  logic [63:0] acc_v;
  logic [3:0]  cnt_v;
  logic        v_over, v_done;
  logic [60:0] tag_num;
  logic [2:0]  tag_wt;
  logic [32:0] used1;
  logic [32:0] rem;
  logic [63:0] acc_fx;
  logic [31:0] left_dec;
  logic [31:0] used_inc;
  logic        msg_end;
  logic        hdr_en, hdr_is_pl;
  result_t     hdr;
  result_t     endr;

  always_comb begin
    vshamt  = ({3'b0, cnt_r} << 3) - {3'b0, cnt_r};
    acc_v   = acc_r | ({57'b0, in_data_byte[6:0]} << vshamt);
    cnt_v   = cnt_r + 4'd1;
    v_over  = (cnt_r >= 4'(MaxVarintBytes)) ||
              (in_data_byte[7] && cnt_v >= 4'(MaxVarintBytes));
    v_done  = !v_over && !in_data_byte[7];
    tag_num = acc_v[63:3];
    tag_wt  = acc_v[2:0];
    used1   = {1'b0, used_r} + 33'd1;
    rem     = ({1'b0, msg_len_r} > used1) ? ({1'b0, msg_len_r} - used1) : 33'd0;
    acc_fx  = acc_r | ({56'b0, in_data_byte} << {cnt_r[2:0], 3'b000});
    left_dec = (left_r != 32'd0) ? left_r - 32'd1 : 32'd0;

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    fn_nxt    = fn_r;
    wt_nxt    = wt_r;
    left_nxt  = left_r;
    depth_nxt = depth_r;
    fail_nxt  = fail_r;
    hdr_en    = 1'b0;
    hdr_is_pl = 1'b0;
    hdr       = '0;

    if (fail_r == ERR_NONE) begin
      case (phase_r)
        PH_TAG: begin
          acc_nxt = acc_v;
          cnt_nxt = cnt_v;
          if (v_over) begin
            fail_nxt = ERR_TAG;
          end else if (v_done) begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (tag_num == 61'd0 || tag_num > {32'b0, max_fn_r}) begin
              fail_nxt = ERR_FIELD;
            end else if (tag_wt == WT_RES6 || tag_wt == WT_RES7) begin
              fail_nxt = ERR_WIRE;
            end else begin
              fn_nxt = tag_num[28:0];
              wt_nxt = tag_wt;
              case (tag_wt)
                WT_SGROUP: begin
                  if (depth_r >= DepthMax) fail_nxt = ERR_DEPTH;
                  else depth_nxt = depth_r + DW'(1);
                end
                WT_EGROUP: begin
                  if (depth_r == '0) fail_nxt = ERR_EGROUP;
                  else depth_nxt = depth_r - DW'(1);
                end
                WT_VARINT: phase_nxt = PH_VARINT;
                WT_LEN:    phase_nxt = PH_LENGTH;
                default: begin
                  phase_nxt = PH_FIXED;
                  left_nxt  = (tag_wt == WT_FIX64) ? 32'd8 : 32'd4;
                end
              endcase
            end
          end
        end
        PH_VARINT: begin
          acc_nxt = acc_v;
          cnt_nxt = cnt_v;
          if (v_over) begin
            fail_nxt = ERR_VARINT;
          end else if (v_done) begin
            hdr_en    = (depth_r == '0);
            hdr.value = acc_v;
            hdr.wire_type = WT_VARINT;
            phase_nxt = PH_TAG;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
        PH_FIXED: begin
          acc_nxt  = acc_fx;
          cnt_nxt  = cnt_v;
          left_nxt = left_dec;
          if (left_dec == 32'd0) begin
            hdr_en    = (depth_r == '0);
            hdr.value = acc_fx;
            hdr.wire_type = wt_r;
            phase_nxt = PH_TAG;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
        PH_LENGTH: begin
          acc_nxt = acc_v;
          cnt_nxt = cnt_v;
          if (v_over) begin
            fail_nxt = ERR_LENGTH;
          end else if (v_done) begin
            if (acc_v > {31'b0, rem}) begin
              fail_nxt = ERR_OVERRUN;
            end else begin
              hdr_en    = (depth_r == '0);
              hdr.value = acc_v;
              hdr.wire_type = WT_LEN;
              phase_nxt = PH_TAG;
              acc_nxt   = '0;
              cnt_nxt   = '0;
              if (acc_v != 64'd0) begin
                left_nxt  = acc_v[31:0];
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          left_nxt  = left_dec;
          hdr_en    = (depth_r == '0);
          hdr_is_pl = 1'b1;
          hdr.wire_type    = WT_LEN;
          hdr.payload_byte = in_data_byte;
          hdr.last_payload = (left_dec == 32'd0);
          if (left_dec == 32'd0) begin
            phase_nxt = PH_TAG;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_TAG;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end
      endcase
    end
    hdr.kind         = hdr_is_pl ? KIND_PAYLOAD : KIND_HEADER;
    hdr.field_number = fn_r;

    // end of message: report an unfinished item, then start over
    used_inc = used_r + 32'd1;
    msg_end  = (used_inc >= msg_len_r) || (used_inc == 32'd0);
    used_nxt = used_inc;
    endr     = '0;
    endr.kind = KIND_END;
    endr.last = 1'b1;
    if (msg_end) begin
      if (fail_nxt == ERR_NONE) begin
        if (phase_nxt == PH_TAG && cnt_nxt != 4'd0) fail_nxt = ERR_TAG;
        else if (phase_nxt == PH_VARINT) fail_nxt = ERR_VARINT;
        else if (phase_nxt == PH_FIXED)
          fail_nxt = (wt_nxt == WT_FIX64) ? ERR_FIX64 : ERR_FIX32;
        else if (phase_nxt == PH_LENGTH) fail_nxt = ERR_LENGTH;
        else if (phase_nxt == PH_PAYLOAD) fail_nxt = ERR_OVERRUN;
        else if (depth_nxt != '0) fail_nxt = ERR_OPEN;
      end
      endr.status = fail_nxt;
      phase_nxt = PH_TAG;
      acc_nxt   = '0;
      cnt_nxt   = '0;
      fn_nxt    = '0;
      wt_nxt    = '0;
      left_nxt  = '0;
      used_nxt  = '0;
      depth_nxt = '0;
      fail_nxt  = ERR_NONE;
    end

    hdr.last = !msg_end;
    if (hdr_en) begin
      res0 = hdr;
      res1 = endr;
      nres = msg_end ? 2'd2 : 2'd1;
    end else begin
      res0 = endr;
      res1 = endr;
      nres = msg_end ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= '0;
      cnt_r   <= '0;
      fn_r    <= '0;
      wt_r    <= '0;
      left_r  <= '0;
      used_r  <= '0;
      depth_r <= '0;
      fail_r  <= ERR_NONE;
    end else if (acc_in) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      fn_r    <= fn_nxt;
      wt_r    <= wt_nxt;
      left_r  <= left_nxt;
      used_r  <= used_nxt;
      depth_r <= depth_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // result queue: up to two writes, one read per cycle
  logic [1:0] nwr;
  assign nwr = acc_in ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (nwr != 2'd0) q_mem[wp_r] <= res0;
    if (nwr == 2'd2) q_mem[wp_r + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      qcnt_r <= '0;
    end else begin
      wp_r   <= wp_r + nwr;
      rp_r   <= rp_r + {1'b0, pop};
      qcnt_r <= qcnt_r + {1'b0, nwr} - {2'b0, pop};
    end
  end

  assign out_kind         = q_mem[rp_r].kind;
  assign out_field_number = q_mem[rp_r].field_number;
  assign out_wire_type    = q_mem[rp_r].wire_type;
  assign out_value        = q_mem[rp_r].value;
  assign out_payload_byte = q_mem[rp_r].payload_byte;
  assign out_last_payload = q_mem[rp_r].last_payload;
  assign out_status       = q_mem[rp_r].status;
  assign out_last         = q_mem[rp_r].last;

  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n) qcnt_r <= 3'd4)
    else $error("result queue overflow");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n) depth_r <= DepthMax)
    else $error("group depth beyond bound");
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != 32'd0)
    else $error("payload phase with nothing left");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && msg_end |=> used_r == 32'd0 && fail_r == ERR_NONE)
    else $error("state not cleared after end of message");

endmodule
